[rtl/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, constants and iteration helpers for the segment/circle test.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

   localparam int COORD_W = 20;
   localparam int RAD_W   = 16;
   localparam int TOL_W   = 16;
   localparam int NORM_W  = 16;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [TOL_W-1:0]  TOL_RESET = 16'd26;
   localparam logic [NORM_W-1:0] NORM_ONE  = 16'd16384;

   // register indexes (word address)
   localparam logic REG_TOL = 1'b0;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic        [RAD_W-1:0]   radius;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic                      hit_with_endpoints;
      logic signed [COORD_W-1:0] contact_x;
      logic signed [COORD_W-1:0] contact_y;
      logic signed [NORM_W-1:0]  normal_x;
      logic signed [NORM_W-1:0]  normal_y;
   } rsp_type;

   // digit-by-digit square root state: remainder and partial root
   typedef struct packed {
      logic [47:0] x;
      logic [47:0] r;
   } sq_type;

   // one root iteration, trial bit 4^i
   function automatic sq_type sqrt_step(sq_type s, int unsigned i);
      sq_type      o;
      logic [47:0] b;
      logic [48:0] t;
      b = 48'(1) << (2 * i);
      t = {1'b0, s.r} + {1'b0, b};
      if ({1'b0, s.x} >= t) begin
         o.x = s.x - t[47:0];
         o.r = (s.r >> 1) + b;
      end else begin
         o.x = s.x;
         o.r = s.r >> 1;
      end
      return o;
   endfunction

   // one restoring division iteration: {quotient bit, new remainder}
   function automatic logic [64:0] div_step(logic [63:0] rem, logic [47:0] den,
                                            int unsigned sh);
      logic [71:0] dsh;
      logic [71:0] r72;
      dsh = 72'(den) << sh;
      r72 = 72'(rem);
      if (r72 >= dsh) begin
         return {1'b1, 64'(r72 - dsh)};
      end
      return {1'b0, rem};
   endfunction

endpackage

`default_nettype wire

[rtl/segment_circle_collision.sv]
// ----------------------------------------------------------------------------
// segment_circle_collision
// Pipelined segment versus circle hit test with contact point and normal.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/ready): one segment plus one circle per transfer.
//  - rsp channel (valid/ready): one result per request, in request order.
//  - csr port (APB style, pready always high): word 0 holds the 16-bit
//    on-segment tolerance in 1/256 pixel; write it only while idle.
//  - One request enters and one result leaves every cycle while the
//    receiver does not stall.
//  - The pipeline depth comes from the bit-per-stage units: a 24-stage divider for
//    the projection (length root computed alongside), a 24-stage root unit
//    for the endpoint distances and the normal length, and a 16-stage
//    divider for the normal.
//  - Reset clears all stage valid bits and sets the tolerance to 26.
//  - When the receiver stalls, the whole pipeline holds in place and
//    req_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_circle_collision (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  scc_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output scc_pkg::rsp_type             rsp_data,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [scc_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire  [scc_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [scc_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import scc_pkg::*;

   localparam int DIV_N  = 24;   // projection divider stages
   localparam int SQ_N   = 24;   // root stages
   localparam int NDIV_N = 16;   // normal divider stages

   localparam logic signed [25:0] CMAX = 26'sd524287;
   localparam logic signed [25:0] CMIN = -26'sd524288;

   // ------------------------------------------------------------------
   // stage types
   // ------------------------------------------------------------------
   typedef struct packed {
      logic                vld;
      req_type             d;
   } a0_type;

   typedef struct packed {
      logic                vld;
      logic signed [19:0]  sx, sy;
      logic signed [20:0]  dx, dy, wx, wy, e1x, e1y, e2x, e2y;
      logic        [31:0]  r2;
   } a1_type;

   typedef struct packed {
      logic                vld;
      logic signed [19:0]  sx, sy;
      logic signed [20:0]  dx, dy, wx, wy;
      logic        [31:0]  r2;
      logic        [40:0]  dxx, dyy, f1x, f1y, f2x, f2y;
      logic signed [41:0]  wdx, wdy;
   } a2_type;

   // fields carried across the projection divider
   typedef struct packed {
      logic signed [19:0]  sx, sy;
      logic signed [20:0]  dx, dy, wx, wy;
      logic        [31:0]  r2;
      logic                ends;
      logic        [40:0]  len2;
   } car_type;

   typedef struct packed {
      logic                vld;
      car_type             c;
      logic signed [41:0]  dot;
   } a3_type;

   typedef struct packed {
      logic                vld;
      car_type             c;
      logic        [40:0]  adot;
      logic        [19:0]  adx, ady;
      logic                negx, negy;
   } a4_type;

   typedef struct packed {
      logic                vld;
      car_type             c;
      logic        [40:0]  plx, ply;
      logic        [39:0]  phx, phy;
      logic                negx, negy;
   } a5_type;

   typedef struct packed {
      logic                vld;
      car_type             c;
      logic        [63:0]  remx, remy;
      logic        [23:0]  qx, qy;
      logic                negx, negy;
      sq_type              lsq;
   } dv_type;

   typedef struct packed {
      logic                vld;
      logic signed [25:0]  qx, qy, ax, ay, vx, vy;
      logic signed [24:0]  offx, offy;
      logic        [23:0]  len;
      logic                lnz, ends;
      logic        [31:0]  r2;
   } p1_type;

   typedef struct packed {
      logic                vld;
      logic signed [25:0]  qx, qy, vx, vy;
      logic        [23:0]  len;
      logic                lnz, ends;
      logic        [31:0]  r2;
      logic        [47:0]  ox2, oy2, ax2, ay2, vx2, vy2;
   } p2_type;

   typedef struct packed {
      logic                vld;
      logic signed [25:0]  qx, qy, vx, vy;
      logic        [23:0]  len;
      logic                lnz, vle, vvnz, ends;
      sq_type              q1, q2, qn;
   } sq_stage_type;

   typedef struct packed {
      logic                vld;
      logic                hit, ends, vvnz;
      logic signed [19:0]  cx, cy;
      logic        [63:0]  remx, remy;
      logic        [15:0]  nqx, nqy;
      logic                negx, negy;
      logic        [23:0]  den;
   } nv_type;

   typedef struct packed {
      logic                vld;
      rsp_type             d;
   } out_type;

   // ------------------------------------------------------------------
   // control: one enable for every stage, held while the output stalls
   // ------------------------------------------------------------------
   logic adv;
   out_type out_ff, out_in;

   assign adv       = !out_ff.vld || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = out_ff.vld;
   assign rsp_data  = out_ff.d;

   // ------------------------------------------------------------------
   // config register
   // ------------------------------------------------------------------
   logic [TOL_W-1:0] tol_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TOL) ? CSR_DW'(tol_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_TOL) begin
         tol_ff <= csr_pwdata[TOL_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // front end: differences, products, sums, magnitudes
   // ------------------------------------------------------------------
   a0_type a0_ff, a0_in;
   a1_type a1_ff, a1_in;
   a2_type a2_ff, a2_in;
   a3_type a3_ff, a3_in;
   a4_type a4_ff, a4_in;
   a5_type a5_ff, a5_in;

   always_comb begin
      a0_in.vld = req_valid;
      a0_in.d   = req_data;
   end

   always_comb begin
      a1_in.vld = a0_ff.vld;
      a1_in.sx  = a0_ff.d.start_x;
      a1_in.sy  = a0_ff.d.start_y;
      a1_in.dx  = 21'(a0_ff.d.end_x) - 21'(a0_ff.d.start_x);
      a1_in.dy  = 21'(a0_ff.d.end_y) - 21'(a0_ff.d.start_y);
      a1_in.wx  = 21'(a0_ff.d.center_x) - 21'(a0_ff.d.start_x);
      a1_in.wy  = 21'(a0_ff.d.center_y) - 21'(a0_ff.d.start_y);
      a1_in.e1x = 21'(a0_ff.d.start_x) - 21'(a0_ff.d.center_x);
      a1_in.e1y = 21'(a0_ff.d.start_y) - 21'(a0_ff.d.center_y);
      a1_in.e2x = 21'(a0_ff.d.end_x) - 21'(a0_ff.d.center_x);
      a1_in.e2y = 21'(a0_ff.d.end_y) - 21'(a0_ff.d.center_y);
      a1_in.r2  = 32'(a0_ff.d.radius) * 32'(a0_ff.d.radius);
   end

   always_comb begin
      logic signed [41:0] t_dxx, t_dyy, t_f1x, t_f1y, t_f2x, t_f2y;
      t_dxx = a1_ff.dx * a1_ff.dx;
      t_dyy = a1_ff.dy * a1_ff.dy;
      t_f1x = a1_ff.e1x * a1_ff.e1x;
      t_f1y = a1_ff.e1y * a1_ff.e1y;
      t_f2x = a1_ff.e2x * a1_ff.e2x;
      t_f2y = a1_ff.e2y * a1_ff.e2y;
      a2_in.vld = a1_ff.vld;
      a2_in.sx  = a1_ff.sx;
      a2_in.sy  = a1_ff.sy;
      a2_in.dx  = a1_ff.dx;
      a2_in.dy  = a1_ff.dy;
      a2_in.wx  = a1_ff.wx;
      a2_in.wy  = a1_ff.wy;
      a2_in.r2  = a1_ff.r2;
      a2_in.dxx = t_dxx[40:0];
      a2_in.dyy = t_dyy[40:0];
      a2_in.f1x = t_f1x[40:0];
      a2_in.f1y = t_f1y[40:0];
      a2_in.f2x = t_f2x[40:0];
      a2_in.f2y = t_f2y[40:0];
      a2_in.wdx = a1_ff.wx * a1_ff.dx;
      a2_in.wdy = a1_ff.wy * a1_ff.dy;
   end

   always_comb begin
      a3_in.vld    = a2_ff.vld;
      a3_in.c.sx   = a2_ff.sx;
      a3_in.c.sy   = a2_ff.sy;
      a3_in.c.dx   = a2_ff.dx;
      a3_in.c.dy   = a2_ff.dy;
      a3_in.c.wx   = a2_ff.wx;
      a3_in.c.wy   = a2_ff.wy;
      a3_in.c.r2   = a2_ff.r2;
      a3_in.c.len2 = a2_ff.dxx + a2_ff.dyy;
      // endpoint inside or on the circle
      a3_in.c.ends = (42'(a2_ff.f1x) + 42'(a2_ff.f1y) <= 42'(a2_ff.r2)) ||
                     (42'(a2_ff.f2x) + 42'(a2_ff.f2y) <= 42'(a2_ff.r2));
      a3_in.dot    = a2_ff.wdx + a2_ff.wdy;
   end

   always_comb begin
      a4_in.vld  = a3_ff.vld;
      a4_in.c    = a3_ff.c;
      a4_in.adot = a3_ff.dot[41] ? 41'(-a3_ff.dot) : 41'(a3_ff.dot);
      a4_in.adx  = a3_ff.c.dx[20] ? 20'(-a3_ff.c.dx) : 20'(a3_ff.c.dx);
      a4_in.ady  = a3_ff.c.dy[20] ? 20'(-a3_ff.c.dy) : 20'(a3_ff.c.dy);
      a4_in.negx = a3_ff.c.dx[20] ^ a3_ff.dot[41];
      a4_in.negy = a3_ff.c.dy[20] ^ a3_ff.dot[41];
   end

   // |d| * |dot| split in two partial products per axis
   always_comb begin
      a5_in.vld  = a4_ff.vld;
      a5_in.c    = a4_ff.c;
      a5_in.plx  = 41'(a4_ff.adx) * 41'(a4_ff.adot[20:0]);
      a5_in.ply  = 41'(a4_ff.ady) * 41'(a4_ff.adot[20:0]);
      a5_in.phx  = 40'(a4_ff.adx) * 40'(a4_ff.adot[40:21]);
      a5_in.phy  = 40'(a4_ff.ady) * 40'(a4_ff.adot[40:21]);
      a5_in.negx = a4_ff.negx;
      a5_in.negy = a4_ff.negy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a0_ff.vld <= 1'b0;
         a1_ff.vld <= 1'b0;
         a2_ff.vld <= 1'b0;
         a3_ff.vld <= 1'b0;
         a4_ff.vld <= 1'b0;
         a5_ff.vld <= 1'b0;
      end else if (adv) begin
         a0_ff <= a0_in;
         a1_ff <= a1_in;
         a2_ff <= a2_in;
         a3_ff <= a3_in;
         a4_ff <= a4_in;
         a5_ff <= a5_in;
      end
   end

   // ------------------------------------------------------------------
   // projection divider, one quotient bit per stage; length root alongside
   // ------------------------------------------------------------------
   dv_type dv_ff [0:DIV_N];
   dv_type dv0_in;

   always_comb begin
      dv0_in.vld   = a5_ff.vld;
      dv0_in.c     = a5_ff.c;
      // numerator magnitude plus half the divisor for round half away
      dv0_in.remx  = (64'(a5_ff.phx) << 21) + 64'(a5_ff.plx) + 64'(a5_ff.c.len2 >> 1);
      dv0_in.remy  = (64'(a5_ff.phy) << 21) + 64'(a5_ff.ply) + 64'(a5_ff.c.len2 >> 1);
      dv0_in.qx    = '0;
      dv0_in.qy    = '0;
      dv0_in.negx  = a5_ff.negx;
      dv0_in.negy  = a5_ff.negy;
      dv0_in.lsq.x = 48'(a5_ff.c.len2);
      dv0_in.lsq.r = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0].vld <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= dv0_in;
      end
   end

   for (genvar k = 1; k <= DIV_N; k++) begin : g_div
      dv_type      dv_in;
      logic [64:0] stx, sty;

      assign stx = div_step(dv_ff[k-1].remx, 48'(dv_ff[k-1].c.len2), DIV_N - k);
      assign sty = div_step(dv_ff[k-1].remy, 48'(dv_ff[k-1].c.len2), DIV_N - k);

      always_comb begin
         dv_in             = dv_ff[k-1];
         dv_in.remx        = stx[63:0];
         dv_in.remy        = sty[63:0];
         dv_in.qx[DIV_N-k] = stx[64];
         dv_in.qy[DIV_N-k] = sty[64];
         dv_in.lsq         = sqrt_step(dv_ff[k-1].lsq, DIV_N - k);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k].vld <= 1'b0;
         end else if (adv) begin
            dv_ff[k] <= dv_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // closest point, vectors to endpoints and center, their squares
   // ------------------------------------------------------------------
   p1_type p1_ff, p1_in;
   p2_type p2_ff, p2_in;
   sq_stage_type sq_ff [0:SQ_N];
   sq_stage_type sq0_in;

   always_comb begin
      logic signed [24:0] oqx, oqy, ofx, ofy;
      oqx = $signed({1'b0, dv_ff[DIV_N].qx});
      oqy = $signed({1'b0, dv_ff[DIV_N].qy});
      ofx = dv_ff[DIV_N].negx ? -oqx : oqx;
      ofy = dv_ff[DIV_N].negy ? -oqy : oqy;
      p1_in.vld  = dv_ff[DIV_N].vld;
      p1_in.offx = ofx;
      p1_in.offy = ofy;
      p1_in.qx   = 26'(dv_ff[DIV_N].c.sx) + 26'(ofx);
      p1_in.qy   = 26'(dv_ff[DIV_N].c.sy) + 26'(ofy);
      p1_in.ax   = 26'(ofx) - 26'(dv_ff[DIV_N].c.dx);
      p1_in.ay   = 26'(ofy) - 26'(dv_ff[DIV_N].c.dy);
      p1_in.vx   = 26'(dv_ff[DIV_N].c.wx) - 26'(ofx);
      p1_in.vy   = 26'(dv_ff[DIV_N].c.wy) - 26'(ofy);
      p1_in.len  = dv_ff[DIV_N].lsq.r[23:0];
      p1_in.lnz  = dv_ff[DIV_N].c.len2 != '0;
      p1_in.ends = dv_ff[DIV_N].c.ends;
      p1_in.r2   = dv_ff[DIV_N].c.r2;
   end

   always_comb begin
      logic signed [51:0] t_ox, t_oy, t_ax, t_ay, t_vx, t_vy;
      t_ox = p1_ff.offx * p1_ff.offx;
      t_oy = p1_ff.offy * p1_ff.offy;
      t_ax = p1_ff.ax * p1_ff.ax;
      t_ay = p1_ff.ay * p1_ff.ay;
      t_vx = p1_ff.vx * p1_ff.vx;
      t_vy = p1_ff.vy * p1_ff.vy;
      p2_in.vld  = p1_ff.vld;
      p2_in.qx   = p1_ff.qx;
      p2_in.qy   = p1_ff.qy;
      p2_in.vx   = p1_ff.vx;
      p2_in.vy   = p1_ff.vy;
      p2_in.len  = p1_ff.len;
      p2_in.lnz  = p1_ff.lnz;
      p2_in.ends = p1_ff.ends;
      p2_in.r2   = p1_ff.r2;
      p2_in.ox2  = t_ox[47:0];
      p2_in.oy2  = t_oy[47:0];
      p2_in.ax2  = t_ax[47:0];
      p2_in.ay2  = t_ay[47:0];
      p2_in.vx2  = t_vx[47:0];
      p2_in.vy2  = t_vy[47:0];
   end

   always_comb begin
      logic [47:0] vv;
      vv = p2_ff.vx2 + p2_ff.vy2;
      sq0_in.vld  = p2_ff.vld;
      sq0_in.qx   = p2_ff.qx;
      sq0_in.qy   = p2_ff.qy;
      sq0_in.vx   = p2_ff.vx;
      sq0_in.vy   = p2_ff.vy;
      sq0_in.len  = p2_ff.len;
      sq0_in.lnz  = p2_ff.lnz;
      sq0_in.vle  = vv <= 48'(p2_ff.r2);
      sq0_in.vvnz = vv != '0;
      sq0_in.ends = p2_ff.ends;
      sq0_in.q1.x = p2_ff.ox2 + p2_ff.oy2;
      sq0_in.q1.r = '0;
      sq0_in.q2.x = p2_ff.ax2 + p2_ff.ay2;
      sq0_in.q2.r = '0;
      // only a hit uses the normal, and then vv fits 32 bits
      sq0_in.qn.x = {vv[31:0], 16'b0};
      sq0_in.qn.r = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff.vld    <= 1'b0;
         p2_ff.vld    <= 1'b0;
         sq_ff[0].vld <= 1'b0;
      end else if (adv) begin
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         sq_ff[0] <= sq0_in;
      end
   end

   // ------------------------------------------------------------------
   // three roots in lockstep, one result bit per stage
   // ------------------------------------------------------------------
   for (genvar k = 1; k <= SQ_N; k++) begin : g_sq
      sq_stage_type sq_in;

      always_comb begin
         sq_in    = sq_ff[k-1];
         sq_in.q1 = sqrt_step(sq_ff[k-1].q1, SQ_N - k);
         sq_in.q2 = sqrt_step(sq_ff[k-1].q2, SQ_N - k);
         sq_in.qn = sqrt_step(sq_ff[k-1].qn, SQ_N - k);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ff[k].vld <= 1'b0;
         end else if (adv) begin
            sq_ff[k] <= sq_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // on-segment test, hit decision, normal divider setup
   // ------------------------------------------------------------------
   nv_type nv_ff [0:NDIV_N];
   nv_type nv0_in;

   always_comb begin
      logic signed [26:0] diff, tol;
      logic signed [25:0] avx, avy;
      logic        [23:0] s;
      logic               ontol;
      diff  = 27'($signed({1'b0, sq_ff[SQ_N].q1.r[23:0]})) +
              27'($signed({1'b0, sq_ff[SQ_N].q2.r[23:0]})) -
              27'($signed({1'b0, sq_ff[SQ_N].len}));
      tol   = 27'($signed({1'b0, tol_ff}));
      ontol = (diff <= tol) && (diff >= -tol);
      s     = sq_ff[SQ_N].qn.r[23:0];
      avx   = sq_ff[SQ_N].vx[25] ? -sq_ff[SQ_N].vx : sq_ff[SQ_N].vx;
      avy   = sq_ff[SQ_N].vy[25] ? -sq_ff[SQ_N].vy : sq_ff[SQ_N].vy;

      nv0_in.vld  = sq_ff[SQ_N].vld;
      nv0_in.hit  = sq_ff[SQ_N].lnz && ontol && sq_ff[SQ_N].vle;
      nv0_in.ends = sq_ff[SQ_N].ends;
      nv0_in.vvnz = sq_ff[SQ_N].vvnz;
      // contact saturates to the field range
      if (sq_ff[SQ_N].qx > CMAX) begin
         nv0_in.cx = CMAX[19:0];
      end else if (sq_ff[SQ_N].qx < CMIN) begin
         nv0_in.cx = CMIN[19:0];
      end else begin
         nv0_in.cx = sq_ff[SQ_N].qx[19:0];
      end
      if (sq_ff[SQ_N].qy > CMAX) begin
         nv0_in.cy = CMAX[19:0];
      end else if (sq_ff[SQ_N].qy < CMIN) begin
         nv0_in.cy = CMIN[19:0];
      end else begin
         nv0_in.cy = sq_ff[SQ_N].qy[19:0];
      end
      // |v| * 2^22 + s/2; on a hit |v| stays below 2^16
      nv0_in.remx = (64'(avx[16:0]) << 22) + 64'(s >> 1);
      nv0_in.remy = (64'(avy[16:0]) << 22) + 64'(s >> 1);
      nv0_in.nqx  = '0;
      nv0_in.nqy  = '0;
      nv0_in.negx = sq_ff[SQ_N].vx[25];
      nv0_in.negy = sq_ff[SQ_N].vy[25];
      nv0_in.den  = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff[0].vld <= 1'b0;
      end else if (adv) begin
         nv_ff[0] <= nv0_in;
      end
   end

   for (genvar k = 1; k <= NDIV_N; k++) begin : g_ndiv
      nv_type      nv_in;
      logic [64:0] stx, sty;

      assign stx = div_step(nv_ff[k-1].remx, 48'(nv_ff[k-1].den), NDIV_N - k);
      assign sty = div_step(nv_ff[k-1].remy, 48'(nv_ff[k-1].den), NDIV_N - k);

      always_comb begin
         nv_in               = nv_ff[k-1];
         nv_in.remx          = stx[63:0];
         nv_in.remy          = sty[63:0];
         nv_in.nqx[NDIV_N-k] = stx[64];
         nv_in.nqy[NDIV_N-k] = sty[64];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nv_ff[k].vld <= 1'b0;
         end else if (adv) begin
            nv_ff[k] <= nv_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // output register: clamp, sign, zero on miss
   // ------------------------------------------------------------------
   always_comb begin
      logic [15:0] mx, my;
      logic        show_n;
      mx     = (nv_ff[NDIV_N].nqx > NORM_ONE) ? NORM_ONE : nv_ff[NDIV_N].nqx;
      my     = (nv_ff[NDIV_N].nqy > NORM_ONE) ? NORM_ONE : nv_ff[NDIV_N].nqy;
      show_n = nv_ff[NDIV_N].hit && nv_ff[NDIV_N].vvnz;

      out_in.vld                  = nv_ff[NDIV_N].vld;
      out_in.d.hit                = nv_ff[NDIV_N].hit;
      out_in.d.hit_with_endpoints = nv_ff[NDIV_N].hit || nv_ff[NDIV_N].ends;
      out_in.d.contact_x          = nv_ff[NDIV_N].hit ? nv_ff[NDIV_N].cx : '0;
      out_in.d.contact_y          = nv_ff[NDIV_N].hit ? nv_ff[NDIV_N].cy : '0;
      if (!show_n) begin
         out_in.d.normal_x = '0;
         out_in.d.normal_y = '0;
      end else begin
         out_in.d.normal_x = nv_ff[NDIV_N].negx ? -$signed(mx) : $signed(mx);
         out_in.d.normal_y = nv_ff[NDIV_N].negy ? -$signed(my) : $signed(my);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.vld <= 1'b0;
      end else if (adv) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire
